>>> design/rprt_pkg.sv
package rprt_pkg;

  localparam int unsigned PN_W      = 62;
  localparam int unsigned ENTRY_W   = 2 * PN_W;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 72;

  typedef logic [PN_W-1:0]     pn_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_DONE    = 2'd0;
  localparam status_t STATUS_DUP     = 2'd1;
  localparam status_t STATUS_IGNORED = 2'd2;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_FORGET = 1'b1;

endpackage

>>> design/rprt_ram.sv
module rprt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/received_packet_range_tracker.sv
// channel   dir  tdata                                      tuser
// s_axis    in   [61:0] rx_pn                               [0] op
// m_axis    out  [61:0] largest_received, [67:62] held_count [1:0] status
//
// record: the transfer is taken, then the ranges are scanned one by one until the
//   number's place is found, a decide step follows, and entries are moved one by
//   one when two ranges merge, or moved and then the new range written when a range
//   is inserted (at most MAX_RANGES - 1 moves); last the result is output
// forget: held ranges are trimmed or dropped one at a time, as the range table has one port pair
// reset clears the range count, floor and control; table contents stay unknown
// an input transfer is taken while the previous result still waits on m_axis;
//   the output cycle then stalls until that result is taken
module received_packet_range_tracker #(
  parameter int unsigned MAX_RANGES = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [rprt_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,   // [61:0] rx_pn
  input  logic                                 s_axis_tuser_i,   // [0] op
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [rprt_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,   // largest_received, held_count
  output logic [rprt_pkg::STATUS_W-1:0]        m_axis_tuser_o    // status
);

  localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_RANGES);
  localparam logic [CW-1:0] LastIdx = CW'(MAX_RANGES - 1);
  localparam logic [CW-1:0] One = CW'(1);
  localparam logic [CW-1:0] Two = CW'(2);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_DECIDE    = 3'd2;
  localparam logic [2:0] S_REMOVE    = 3'd3;
  localparam logic [2:0] S_INS_SHIFT = 3'd4;
  localparam logic [2:0] S_INS_WRITE = 3'd5;
  localparam logic [2:0] S_FORGET    = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic [2:0]              state_q, state_d;
  logic                    op_q, op_d;
  rprt_pkg::pn_t           pn_q, pn_d;
  rprt_pkg::status_t       status_q, status_d;
  logic [CW-1:0]           held_q, held_d;
  rprt_pkg::pn_t           floor_q, floor_d;
  rprt_pkg::pn_t           top_high_q, top_high_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           idx2_q, idx2_d;
  logic                    found_q, found_d;
  rprt_pkg::pn_t           above_low_q, above_low_d;
  rprt_pkg::pn_t           above_high_q, above_high_d;
  rprt_pkg::pn_t           cur_low_q, cur_low_d;
  rprt_pkg::pn_t           cur_high_q, cur_high_d;

  logic                    out_valid_q, out_valid_d;
  rprt_pkg::status_t       out_status_q, out_status_d;
  rprt_pkg::pn_t           out_largest_q, out_largest_d;
  logic [rprt_pkg::COUNT_W-1:0] out_count_q, out_count_d;

  logic                         ram_we;
  logic                         ram_re;
  logic [CW-1:0]                wr_idx;
  logic [CW-1:0]                rd_idx;
  logic [rprt_pkg::ENTRY_W-1:0] ram_wdata;
  logic [rprt_pkg::ENTRY_W-1:0] ram_rdata;
  rprt_pkg::pn_t                rd_low;
  rprt_pkg::pn_t                rd_high;
  logic                         in_xfer;
  logic                         out_xfer;
  logic                         ext_down;
  logic                         ext_up;

  assign rd_low  = ram_rdata[rprt_pkg::PN_W-1:0];
  assign rd_high = ram_rdata[rprt_pkg::ENTRY_W-1:rprt_pkg::PN_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = out_valid_q && m_axis_tready_i;

  // shared merge compares on the latched neighbors
  assign ext_down = (idx_q != '0) && (above_low_q != '0) && ((above_low_q - 1'b1) == pn_q);
  assign ext_up   = found_q && (({1'b0, cur_high_q} + 1'b1) == {1'b0, pn_q});

  rprt_ram #(
    .WIDTH (rprt_pkg::ENTRY_W),
    .DEPTH (MAX_RANGES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic [CW-1:0] last;
    logic          keep;
    logic [CW-1:0] w_next;
    last   = (held_q < MaxCnt) ? held_q : LastIdx;
    keep   = (rd_high >= pn_q);
    w_next = idx2_q + (keep ? One : '0);

    state_d      = state_q;
    op_d         = op_q;
    pn_d         = pn_q;
    status_d     = status_q;
    held_d       = held_q;
    floor_d      = floor_q;
    idx_d        = idx_q;
    idx2_d       = idx2_q;
    found_d      = found_q;
    above_low_d  = above_low_q;
    above_high_d = above_high_q;
    cur_low_d    = cur_low_q;
    cur_high_d   = cur_high_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    wr_idx       = '0;
    rd_idx       = '0;
    ram_wdata    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d     = s_axis_tuser_i;
          pn_d     = s_axis_tdata_i[rprt_pkg::PN_W-1:0];
          status_d = rprt_pkg::STATUS_DONE;
          idx_d    = '0;
          idx2_d   = '0;
          found_d  = 1'b0;
          if (s_axis_tuser_i == rprt_pkg::OP_RECORD) begin
            if (held_q == '0) begin
              state_d = S_DECIDE;
            end else begin
              ram_re  = 1'b1;
              state_d = S_SCAN;
            end
          end else if (s_axis_tdata_i[rprt_pkg::PN_W-1:0] < floor_q) begin
            status_d = rprt_pkg::STATUS_IGNORED;
            state_d  = S_DONE;
          end else begin
            floor_d = s_axis_tdata_i[rprt_pkg::PN_W-1:0];
            if (held_q == '0) begin
              state_d = S_DONE;
            end else begin
              ram_re  = 1'b1;
              state_d = S_FORGET;
            end
          end
        end
      end
      S_SCAN: begin
        if (pn_q <= rd_high) begin
          if (pn_q >= rd_low) begin
            status_d = rprt_pkg::STATUS_DUP;
            state_d  = S_DONE;
          end else begin
            above_low_d  = rd_low;
            above_high_d = rd_high;
            idx_d        = idx_q + One;
            if ((idx_q + One) == held_q) begin
              state_d = S_DECIDE;
            end else begin
              ram_re = 1'b1;
              rd_idx = idx_q + One;
            end
          end
        end else begin
          found_d    = 1'b1;
          cur_low_d  = rd_low;
          cur_high_d = rd_high;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
        if (ext_down && ext_up) begin
          ram_we    = 1'b1;
          wr_idx    = idx_q - One;
          ram_wdata = {above_high_q, cur_low_q};
          if ((idx_q + One) < held_q) begin
            ram_re  = 1'b1;
            rd_idx  = idx_q + One;
            idx2_d  = idx_q;
            state_d = S_REMOVE;
          end else begin
            held_d = held_q - One;
          end
        end else if (ext_down) begin
          ram_we    = 1'b1;
          wr_idx    = idx_q - One;
          ram_wdata = {above_high_q, pn_q};
        end else if (ext_up) begin
          ram_we    = 1'b1;
          wr_idx    = idx_q;
          ram_wdata = {pn_q, cur_low_q};
        end else if (found_q) begin
          if (last > idx_q) begin
            ram_re  = 1'b1;
            rd_idx  = last - One;
            idx2_d  = last;
            state_d = S_INS_SHIFT;
          end else begin
            state_d = S_INS_WRITE;
          end
        end else if (held_q < MaxCnt) begin
          ram_we    = 1'b1;
          wr_idx    = held_q;
          ram_wdata = {pn_q, pn_q};
          held_d    = held_q + One;
        end
      end
      S_REMOVE: begin
        ram_we    = 1'b1;
        wr_idx    = idx2_q;
        ram_wdata = ram_rdata;
        if ((idx2_q + Two) < held_q) begin
          ram_re = 1'b1;
          rd_idx = idx2_q + Two;
          idx2_d = idx2_q + One;
        end else begin
          held_d  = held_q - One;
          state_d = S_DONE;
        end
      end
      S_INS_SHIFT: begin
        ram_we    = 1'b1;
        wr_idx    = idx2_q;
        ram_wdata = ram_rdata;
        if ((idx2_q - One) > idx_q) begin
          ram_re = 1'b1;
          rd_idx = idx2_q - Two;
          idx2_d = idx2_q - One;
        end else begin
          state_d = S_INS_WRITE;
        end
      end
      S_INS_WRITE: begin
        ram_we    = 1'b1;
        wr_idx    = idx_q;
        ram_wdata = {pn_q, pn_q};
        if (held_q < MaxCnt) begin
          held_d = held_q + One;
        end
        state_d = S_DONE;
      end
      S_FORGET: begin
        if (keep) begin
          ram_we    = 1'b1;
          wr_idx    = idx2_q;
          ram_wdata = {rd_high, (rd_low < pn_q) ? pn_q : rd_low};
        end
        idx2_d = w_next;
        if ((idx_q + One) < held_q) begin
          ram_re = 1'b1;
          rd_idx = idx_q + One;
          idx_d  = idx_q + One;
        end else begin
          held_d  = w_next;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // entry 0 high end kept beside the table
  always_comb begin
    top_high_d = top_high_q;
    if (ram_we && (wr_idx == '0)) begin
      top_high_d = ram_wdata[rprt_pkg::ENTRY_W-1:rprt_pkg::PN_W];
    end
  end

  always_comb begin
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_largest_d = out_largest_q;
    out_count_d   = out_count_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready_i)) begin
      out_valid_d   = 1'b1;
      out_status_d  = status_q;
      out_largest_d = (held_q != '0) ? top_high_q : '0;
      out_count_d   = rprt_pkg::COUNT_W'(held_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      floor_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      floor_q     <= floor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    pn_q          <= pn_d;
    status_q      <= status_d;
    top_high_q    <= top_high_d;
    idx_q         <= idx_d;
    idx2_q        <= idx2_d;
    found_q       <= found_d;
    above_low_q   <= above_low_d;
    above_high_q  <= above_high_d;
    cur_low_q     <= cur_low_d;
    cur_high_q    <= cur_high_d;
    out_status_q  <= out_status_d;
    out_largest_q <= out_largest_d;
    out_count_q   <= out_count_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{(rprt_pkg::OUT_DATA_W - rprt_pkg::PN_W - rprt_pkg::COUNT_W){1'b0}},
                            out_count_q, out_largest_q};

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= MaxCnt)
    else $error("range count above table size");

  a_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_xfer) |=> $stable(held_q) && $stable(floor_q))
    else $error("table state changed without an item");

  a_write_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (wr_idx < MaxCnt))
    else $error("table write beyond depth");

  a_dup_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && state_d == S_DONE) |=> $stable(held_q))
    else $error("duplicate changed range count");

  a_ignored_keeps_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == rprt_pkg::STATUS_IGNORED) |-> op_q == rprt_pkg::OP_FORGET)
    else $error("ignored status on a record item");

endmodule

>>> dv/received_packet_range_tracker_test.sv
module received_packet_range_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 32;
  localparam int CYCLE_LIMIT = 500_000;
  localparam rprt_pkg::pn_t PN_MAX = '1;

  typedef struct packed {
    logic          op;
    rprt_pkg::pn_t pn;
  } pn_item_t;

  typedef struct packed {
    rprt_pkg::status_t status;
    rprt_pkg::pn_t     largest;
    logic [5:0]        count;
  } range_summary_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                            s_valid = 1'b0;
  logic [rprt_pkg::IN_DATA_W-1:0]  s_data = '0;
  logic                            s_op = rprt_pkg::OP_RECORD;
  logic                            s_axis_tready_o;
  logic                            m_axis_tvalid_o;
  logic                            m_ready = 1'b0;
  logic [rprt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  rprt_pkg::status_t               m_axis_tuser_o;

  received_packet_range_tracker #(
    .MAX_RANGES(TABLE_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),    // [61:0] rx_pn
    .s_axis_tuser_i  (s_op),      // [0] op
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o), // [61:0] largest_received, [67:62] held_count
    .m_axis_tuser_o  (m_axis_tuser_o)  // [1:0] status
  );

  // tracker state as predicted
  logic [63:0] span_lo [TABLE_DEPTH];
  logic [63:0] span_hi [TABLE_DEPTH];
  int          held_ranges = 0;
  logic [63:0] floor_pn = '0;

  pn_item_t       pending_items[$];
  range_summary_t expected_summaries[$];
  pn_item_t       live_item;
  rprt_pkg::pn_t  gen_floor = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int n_records = 0;
  int n_forgets = 0;
  int n_dups = 0;
  int n_ignored = 0;
  int n_full = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_summaries.size());
      $display("received_packet_range_tracker_test: done, errors");
      $finish;
    end
  end

  function automatic rprt_pkg::status_t note_number(logic [63:0] pn);
    int   i;
    int   k;
    int   last;
    logic found;
    i = 0;
    while (i < held_ranges && pn <= span_hi[i]) begin
      if (pn >= span_lo[i]) return rprt_pkg::STATUS_DUP;
      i++;
    end
    found = (i < held_ranges);
    // extend the range above downward, merging with the one below if they meet
    if (i > 0 && span_lo[i-1] != 0 && span_lo[i-1] - 1 == pn) begin
      span_lo[i-1] = pn;
      if (found && span_hi[i] + 1 == pn) begin
        span_lo[i-1] = span_lo[i];
        for (k = i; k + 1 < held_ranges; k++) begin
          span_lo[k] = span_lo[k+1];
          span_hi[k] = span_hi[k+1];
        end
        held_ranges--;
      end
      return rprt_pkg::STATUS_DONE;
    end
    if (found && span_hi[i] + 1 == pn) begin
      span_hi[i] = pn;
      return rprt_pkg::STATUS_DONE;
    end
    if (found) begin
      // lowest range falls off when full
      last = (held_ranges < TABLE_DEPTH) ? held_ranges : TABLE_DEPTH - 1;
      for (k = last; k > i; k--) begin
        span_lo[k] = span_lo[k-1];
        span_hi[k] = span_hi[k-1];
      end
      span_lo[i] = pn;
      span_hi[i] = pn;
      if (held_ranges < TABLE_DEPTH) held_ranges++;
    end else if (held_ranges < TABLE_DEPTH) begin
      span_lo[held_ranges] = pn;
      span_hi[held_ranges] = pn;
      held_ranges++;
    end
    return rprt_pkg::STATUS_DONE;
  endfunction

  function automatic rprt_pkg::status_t raise_floor(logic [63:0] f);
    int r;
    int w;
    if (f < floor_pn) return rprt_pkg::STATUS_IGNORED;
    floor_pn = f;
    w = 0;
    for (r = 0; r < held_ranges; r++) begin
      if (span_hi[r] >= f) begin
        span_hi[w] = span_hi[r];
        span_lo[w] = (span_lo[r] < f) ? f : span_lo[r];
        w++;
      end
    end
    held_ranges = w;
    return rprt_pkg::STATUS_DONE;
  endfunction

  function automatic void predict_item(pn_item_t it);
    range_summary_t res;
    if (it.op == rprt_pkg::OP_RECORD) begin
      res.status = note_number({2'b00, it.pn});
      n_records++;
    end else begin
      res.status = raise_floor({2'b00, it.pn});
      n_forgets++;
    end
    if (res.status == rprt_pkg::STATUS_DUP) n_dups++;
    if (res.status == rprt_pkg::STATUS_IGNORED) n_ignored++;
    if (held_ranges == TABLE_DEPTH) n_full++;
    res.largest = (held_ranges > 0) ? span_hi[0][rprt_pkg::PN_W-1:0] : '0;
    res.count   = held_ranges[5:0];
    expected_summaries.push_back(res);
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_input
    pn_item_t staged;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_op    <= rprt_pkg::OP_RECORD;
    end else begin
      if (s_valid && s_axis_tready_o) predict_item(live_item);
      if (!s_valid || s_axis_tready_o) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          staged = pending_items.pop_front();
          live_item <= staged;
          s_valid   <= 1'b1;
          s_data    <= {2'b00, staged.pn};
          s_op      <= staged.op;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : watch_output
    range_summary_t want;
    range_summary_t got;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        got.status  = m_axis_tuser_o;
        got.largest = m_axis_tdata_o[61:0];
        got.count   = m_axis_tdata_o[67:62];
        if (expected_summaries.size() == 0) begin
          flag_mismatch($sformatf("unexpected transfer: status=%0d largest=%h count=%0d",
                                  got.status, got.largest, got.count));
        end else begin
          want = expected_summaries.pop_front();
          if (got.status !== want.status || got.largest !== want.largest ||
              got.count !== want.count)
            flag_mismatch($sformatf(
              "mismatch: expected status=%0d largest=%h count=%0d, got status=%0d largest=%h count=%0d",
              want.status, want.largest, want.count, got.status, got.largest, got.count));
        end
      end
      m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic enqueue(logic op, rprt_pkg::pn_t pn);
    pn_item_t it;
    it.op = op;
    it.pn = pn;
    if (op == rprt_pkg::OP_FORGET && pn > gen_floor) gen_floor = pn;
    pending_items.push_back(it);
  endtask

  // waits until every queued item has been sent and every result has come back
  task automatic drain();
    @(posedge clk_i);
    #1;
    while (pending_items.size() != 0 || s_valid || expected_summaries.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
  endtask

  // a burst of numbers around a base that climbs with e, so the floor keeps moving up
  task automatic queue_episode(int e);
    logic [63:0] base;
    int          w;
    int          stride;
    int          roll;
    base   = e * 64'h0555_5555_5555_5555 + {32'h0, $urandom} + 64'd1024;
    w      = $urandom_range(6, 60);
    stride = $urandom_range(1, 2);
    repeat (46) begin
      roll = $urandom_range(0, 99);
      if (roll < 78)
        enqueue(rprt_pkg::OP_RECORD,
                rprt_pkg::pn_t'(base + stride * $urandom_range(0, w)));
      else if (roll < 83)
        enqueue(rprt_pkg::OP_RECORD, rprt_pkg::pn_t'(base - $urandom_range(1, 30)));
      else if (roll < 88)
        enqueue(rprt_pkg::OP_RECORD, rprt_pkg::pn_t'({$urandom, $urandom}));
      else if (roll < 96)
        enqueue(rprt_pkg::OP_FORGET,
                rprt_pkg::pn_t'(base + $urandom_range(0, stride * w)));
      else if (roll < 98 || gen_floor == 0)
        enqueue(rprt_pkg::OP_FORGET, gen_floor);
      else
        enqueue(rprt_pkg::OP_FORGET, gen_floor - 1);
    end
  endtask

  initial begin : stimulus
    int ph;
    int k;
    @(posedge rst_ni);

    // empty table, small ranges growing, merging and trimmed by the floor
    enqueue(rprt_pkg::OP_FORGET, 0);
    enqueue(rprt_pkg::OP_RECORD, 0);
    enqueue(rprt_pkg::OP_RECORD, 0);
    enqueue(rprt_pkg::OP_RECORD, 1);
    enqueue(rprt_pkg::OP_RECORD, 3);
    enqueue(rprt_pkg::OP_RECORD, 2);
    enqueue(rprt_pkg::OP_RECORD, 10);
    enqueue(rprt_pkg::OP_RECORD, 9);
    enqueue(rprt_pkg::OP_RECORD, 20);
    enqueue(rprt_pkg::OP_RECORD, 15);
    enqueue(rprt_pkg::OP_RECORD, 16);
    enqueue(rprt_pkg::OP_RECORD, 14);
    enqueue(rprt_pkg::OP_RECORD, 12);
    enqueue(rprt_pkg::OP_RECORD, 13);
    enqueue(rprt_pkg::OP_FORGET, 11);
    enqueue(rprt_pkg::OP_FORGET, 10);
    enqueue(rprt_pkg::OP_FORGET, 11);
    enqueue(rprt_pkg::OP_FORGET, 14);
    enqueue(rprt_pkg::OP_RECORD, 5);
    enqueue(rprt_pkg::OP_RECORD, 62'h2AAA_AAAA_AAAA_AAAA);
    enqueue(rprt_pkg::OP_RECORD, 62'h1555_5555_5555_5555);
    enqueue(rprt_pkg::OP_FORGET, 256);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (k = 0; k < 3; k++) queue_episode(ph * 3 + k);
      drain();
    end

    // top of the number space
    enqueue(rprt_pkg::OP_RECORD, PN_MAX);
    enqueue(rprt_pkg::OP_RECORD, PN_MAX - 1);
    enqueue(rprt_pkg::OP_RECORD, PN_MAX);
    enqueue(rprt_pkg::OP_FORGET, PN_MAX);
    enqueue(rprt_pkg::OP_FORGET, PN_MAX - 1);
    enqueue(rprt_pkg::OP_RECORD, 0);
    enqueue(rprt_pkg::OP_FORGET, PN_MAX);
    drain();
    repeat (80) @(posedge clk_i);

    if (expected_summaries.size() != 0 || pending_items.size() != 0)
      flag_mismatch($sformatf("%0d results and %0d items left over",
                              expected_summaries.size(), pending_items.size()));

    $display("covered %0d records and %0d forgets over four idling mixes", n_records,
             n_forgets);
    $display("duplicates %0d, ignored forgets %0d, items leaving the table full %0d",
             n_dups, n_ignored, n_full);
    if (mismatch_count == 0) begin
      $display("received_packet_range_tracker_test: done, clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("received_packet_range_tracker_test: done, errors");
    end
    $finish;
  end

endmodule

>>> received_packet_range_tracker.f
design/rprt_pkg.sv
design/rprt_ram.sv
design/received_packet_range_tracker.sv
dv/received_packet_range_tracker_test.sv
